[hdl/cesc_pkg.sv]
// Package for the console output escaper: character constants, mode codes
// and the translated-run type shared by the translator and the top level.
// No dependencies.
`default_nettype none

package cesc_pkg;

  // Mode codes; any other code behaves as cooked without LF expansion
  localparam logic [1:0] MODE_RAW    = 2'd0;
  localparam logic [1:0] MODE_COOKED = 2'd1;
  localparam logic [1:0] MODE_CRLF   = 2'd2;

  // Character constants
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  localparam int unsigned RunMax = 4;
  localparam int unsigned IdxW   = $clog2(RunMax);

  // One translated input byte: up to four display bytes and the index of
  // the final one, plus the flush marker for that final byte
  typedef struct packed {
    logic [RunMax-1:0][7:0] bytes;
    logic [IdxW-1:0]        last_idx;
    logic                   flush;
  } run_t;

endpackage : cesc_pkg

`default_nettype wire

[hdl/cesc_if.sv]
// Valid/ready channel interfaces for the console output escaper: one for
// console bytes coming in, one for display bytes going out. No dependencies.
`default_nettype none

interface cesc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic [1:0] mode;
  logic       block_end;

  modport source (output valid, char_byte, mode, block_end, input ready);
  modport sink   (input valid, char_byte, mode, block_end, output ready);
endinterface : cesc_in_if

interface cesc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       flush_point;

  modport source (output valid, out_byte, last_of_run, flush_point, input ready);
  modport sink   (input valid, out_byte, last_of_run, flush_point, output ready);
endinterface : cesc_out_if

`default_nettype wire

[hdl/cesc_translate.sv]
// Combinational translation of one console byte into its display run
// (raw, caret or octal escape, LF to CR LF). Depends on cesc_pkg.
`default_nettype none

module cesc_translate (
  input  wire logic [7:0]   char_byte_i,
  input  wire logic [1:0]   mode_i,
  input  wire logic         block_end_i,
  output cesc_pkg::run_t    run_o
);
  import cesc_pkg::*;

  logic passes;

  // Bytes that cooked mode leaves alone
  assign passes = ((char_byte_i >= CH_SPACE) && (char_byte_i <= CH_TILDE)) ||
                  (char_byte_i == CH_FF) || (char_byte_i == CH_BEL) ||
                  (char_byte_i == CH_CR) || (char_byte_i == CH_LF);

  // Pick the run; unused byte slots are don't-care but held at zero
  always_comb begin
    run_o          = '0;
    run_o.flush    = block_end_i;
    if (mode_i == MODE_RAW) begin
      run_o.bytes[0] = char_byte_i;
      run_o.last_idx = IdxW'(0);
    end else if ((mode_i == MODE_CRLF) && (char_byte_i == CH_LF)) begin
      run_o.bytes[0] = CH_CR;
      run_o.bytes[1] = CH_LF;
      run_o.last_idx = IdxW'(1);
    end else if (passes) begin
      run_o.bytes[0] = char_byte_i;
      run_o.last_idx = IdxW'(0);
    end else if (char_byte_i < CH_SPACE) begin
      run_o.bytes[0] = CH_CARET;
      run_o.bytes[1] = CH_AT + char_byte_i;
      run_o.last_idx = IdxW'(1);
    end else begin
      // DEL and the upper half: backslash and three octal digits
      run_o.bytes[0] = CH_BSLASH;
      run_o.bytes[1] = CH_ZERO + {6'd0, char_byte_i[7:6]};
      run_o.bytes[2] = CH_ZERO + {5'd0, char_byte_i[5:3]};
      run_o.bytes[3] = CH_ZERO + {5'd0, char_byte_i[2:0]};
      run_o.last_idx = IdxW'(3);
    end
  end

endmodule : cesc_translate

`default_nettype wire

[hdl/console_output_escaper.sv]
// Top level of the console output escaper: input register, translator and
// a run register that serializes display bytes. Depends on cesc_pkg,
// cesc_in_if, cesc_out_if and cesc_translate.
//
// Usage:
//   in_i  carries one console byte per transaction with its mode
//         (raw, cooked, cooked with LF to CR LF) and a block_end marker.
//   out_o carries one display byte per transaction; last_of_run marks the
//         final byte of an input's run and flush_point repeats block_end there.
//   Path: the first display byte of an input passes the input register,
//   then the run register, before it is offered on out_o.
//   Throughput: the output moves one byte per cycle while out_o.ready is
//   high; an input yields 1 to 4 display bytes: 1 for pass-through bytes,
//   2 for caret escapes and CR LF, 4 for octal escapes. The run register is
//   the limit; while it drains, the input register still takes one more byte.
//   Reset: rst_ni clears both valid flags and the byte index; no output is
//   offered until a new input arrives.
//   Stall: when out_o.ready is low the current byte holds, the run register
//   holds, and in_i.ready drops once the input register is also full.
`default_nettype none

module console_output_escaper (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cesc_in_if.sink   in_i,
  cesc_out_if.source out_o
);
  import cesc_pkg::*;

  // Input register
  logic       in_vld_q;
  logic [7:0] char_q;
  logic [1:0] mode_q;
  logic       blk_end_q;

  // Run register
  logic            run_vld_q;
  run_t            run_q;
  run_t            run_d;
  logic [IdxW-1:0] idx_q;

  logic out_fire;
  logic run_done;
  logic load_run;
  logic in_fire;

  assign out_fire = out_o.valid && out_o.ready;
  assign run_done = out_fire && (idx_q == run_q.last_idx);
  assign load_run = in_vld_q && (!run_vld_q || run_done);
  assign in_i.ready = !in_vld_q || load_run;
  assign in_fire  = in_i.valid && in_i.ready;

  // Capture the incoming transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      char_q    <= in_i.char_byte;
      mode_q    <= in_i.mode;
      blk_end_q <= in_i.block_end;
    end
  end

  cesc_translate u_translate (
    .char_byte_i (char_q),
    .mode_i      (mode_q),
    .block_end_i (blk_end_q),
    .run_o       (run_d)
  );

  // Load a new run or advance through the current one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_vld_q <= 1'b0;
      idx_q     <= '0;
    end else if (load_run) begin
      run_vld_q <= 1'b1;
      idx_q     <= '0;
    end else if (run_done) begin
      run_vld_q <= 1'b0;
      idx_q     <= '0;
    end else if (out_fire) begin
      idx_q     <= idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_run) begin
      run_q <= run_d;
    end
  end

  // Drive the current display byte
  assign out_o.valid       = run_vld_q;
  assign out_o.out_byte    = run_q.bytes[idx_q];
  assign out_o.last_of_run = (idx_q == run_q.last_idx);
  assign out_o.flush_point = (idx_q == run_q.last_idx) && run_q.flush;

endmodule : console_output_escaper

`default_nettype wire

[tb/console_output_escaper_test.sv]
// Self-checking testbench for console_output_escaper: drives console bytes
// in all modes and checks every display byte against its own escaping model.
// Depends on cesc_pkg, cesc_in_if, cesc_out_if and console_output_escaper.
`default_nettype none

module console_output_escaper_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cesc_pkg::*;

  localparam int RandomItems = 250;
  localparam int DrainCycles = 10;

  typedef struct {
    logic [7:0] char_byte;
    logic [1:0] mode;
    logic       block_end;
  } console_item_t;

  typedef struct {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       flush_point;
  } display_byte_t;

  logic clk;
  logic rst_n;

  cesc_in_if  in_if ();
  cesc_out_if out_if ();

  console_output_escaper dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  console_item_t pending_items[$];
  display_byte_t expected_display[$];
  console_item_t next_item;
  display_byte_t want;
  logic          in_fire;
  int            items_total;
  int            items_sent;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            mismatches;

  // Clock
  always #2 clk = ~clk;

  // Escape one console byte into its run of display bytes
  task automatic escape_byte(input logic [7:0] c, input logic [1:0] m, input logic blk);
    logic [7:0] run [4];
    int n;
    if (m == MODE_RAW) begin
      run[0] = c;
      n = 1;
    end else if (m == MODE_CRLF && c == CH_LF) begin
      run[0] = CH_CR;
      run[1] = CH_LF;
      n = 2;
    end else if ((c >= CH_SPACE && c <= CH_TILDE) || c == CH_FF || c == CH_BEL ||
                 c == CH_CR || c == CH_LF) begin
      run[0] = c;
      n = 1;
    end else if (c < CH_SPACE) begin
      run[0] = CH_CARET;
      run[1] = CH_AT + c;
      n = 2;
    end else begin
      // DEL and the upper half: backslash and three octal digits
      run[0] = CH_BSLASH;
      run[1] = CH_ZERO + {6'b0, c[7:6]};
      run[2] = CH_ZERO + {5'b0, c[5:3]};
      run[3] = CH_ZERO + {5'b0, c[2:0]};
      n = 4;
    end
    for (int k = 0; k < n; k++) begin
      expected_display.push_back('{run[k], k == n - 1, (k == n - 1) && blk});
    end
  endtask

  task automatic queue_char(input logic [7:0] c, input logic [1:0] m, input logic blk);
    pending_items.push_back('{c, m, blk});
  endtask

  // Pick a byte that favors the interesting classes
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1, 2: pick_char = 8'($urandom_range(0, 255));
      3, 4:    pick_char = 8'($urandom_range(0, 31));
      5:       pick_char = CH_LF;
      6:       pick_char = 8'($urandom_range(127, 255));
      default: pick_char = 8'($urandom_range(32, 126));
    endcase
  endfunction

  // Monitor: check display transactions, predict on console transactions
  always @(posedge clk) begin
    in_fire <= rst_n && in_if.valid && in_if.ready;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_display.size() == 0) begin
        $display("%0t: unexpected display byte %h last %b flush %b", $time,
                 out_if.out_byte, out_if.last_of_run, out_if.flush_point);
        mismatches++;
      end else begin
        want = expected_display.pop_front();
        if (out_if.out_byte !== want.out_byte) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.out_byte,
                   out_if.out_byte);
          mismatches++;
        end
        if (out_if.last_of_run !== want.last_of_run) begin
          $display("%0t: last_of_run expected %b actual %b", $time, want.last_of_run,
                   out_if.last_of_run);
          mismatches++;
        end
        if (out_if.flush_point !== want.flush_point) begin
          $display("%0t: flush_point expected %b actual %b", $time, want.flush_point,
                   out_if.flush_point);
          mismatches++;
        end
      end
    end
    if (rst_n && in_if.valid && in_if.ready) begin
      escape_byte(in_if.char_byte, in_if.mode, in_if.block_end);
    end
  end

  // Driver: advance the console channel and toggle the display ready
  always @(negedge clk) begin
    if (rst_n) begin
      // Idle pattern: slow receiver, then slow sender, then no idling
      if (items_sent < items_total / 3) begin
        send_idle_pct = 7;
        recv_idle_pct = 49;
      end else if (items_sent < 2 * items_total / 3) begin
        send_idle_pct = 49;
        recv_idle_pct = 7;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (in_fire || !in_if.valid) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_item = pending_items.pop_front();
          in_if.valid     <= 1'b1;
          in_if.char_byte <= next_item.char_byte;
          in_if.mode      <= next_item.mode;
          in_if.block_end <= next_item.block_end;
          items_sent++;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Stimulus and end of run
  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.char_byte = 8'h00;
    in_if.mode      = MODE_RAW;
    in_if.block_end = 1'b0;
    out_if.ready    = 1'b0;
    in_fire         = 1'b0;
    items_sent      = 0;
    mismatches      = 0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;

    // Directed: field extremes, every mode, each character class
    queue_char(8'h00, MODE_RAW, 1'b0);
    queue_char(8'hFF, MODE_RAW, 1'b1);
    queue_char(CH_LF, MODE_RAW, 1'b0);
    queue_char(8'h00, MODE_COOKED, 1'b1);
    queue_char(8'h1F, MODE_COOKED, 1'b0);
    queue_char(CH_SPACE, MODE_COOKED, 1'b0);
    queue_char(CH_TILDE, MODE_COOKED, 1'b1);
    queue_char(8'h7F, MODE_COOKED, 1'b0);
    queue_char(8'h80, MODE_COOKED, 1'b1);
    queue_char(8'hC0, MODE_COOKED, 1'b0);
    queue_char(8'hFF, MODE_COOKED, 1'b1);
    queue_char(CH_FF, MODE_COOKED, 1'b0);
    queue_char(CH_BEL, MODE_COOKED, 1'b0);
    queue_char(CH_CR, MODE_COOKED, 1'b0);
    queue_char(CH_LF, MODE_COOKED, 1'b1);
    queue_char(CH_LF, MODE_CRLF, 1'b0);
    queue_char(CH_LF, MODE_CRLF, 1'b1);
    queue_char(CH_CR, MODE_CRLF, 1'b0);
    queue_char(8'h1B, MODE_CRLF, 1'b1);
    queue_char(8'hA5, MODE_CRLF, 1'b0);
    // Mode three behaves as cooked without LF expansion
    queue_char(CH_LF, 2'd3, 1'b1);
    queue_char(8'h01, 2'd3, 1'b0);
    queue_char(8'hFE, 2'd3, 1'b1);
    queue_char(8'h41, 2'd3, 1'b0);

    // Random: whole byte range, all four mode codes, both marker values
    for (int i = 0; i < RandomItems; i++) begin
      queue_char(pick_char(), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    end
    items_total = pending_items.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Drain: all items taken, all results seen, then a quiet tail
    while (pending_items.size() != 0 || in_if.valid) @(posedge clk);
    while (expected_display.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0 && expected_display.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400_000;
    $display("Some tests failed");
    $finish;
  end

endmodule : console_output_escaper_test

`default_nettype wire
